// ===== src/asu_pkg.sv =====
`timescale 1ns / 1ps
// shared widths, defaults and control types for the sort statistics unit
package asu_pkg;

   localparam int unsigned SAMPLE_W      = 16;
   localparam int unsigned MEAN_W        = 24;
   localparam int unsigned MEDIAN_W      = 17;
   localparam int unsigned COUNT_W       = 7;
   localparam int unsigned FRAC_W        = 8;
   localparam int unsigned DEPTH_DEFAULT = 64;

   // per-cycle command to every cell of the chain, highest priority first
   typedef struct packed {
      logic clear;
      logic drain;
      logic rotate;
      logic insert;
   } cell_ctrl_type;

endpackage

// ===== src/asu_req_if.sv =====
`timescale 1ns / 1ps
// input channel: one sample per transaction
interface asu_req_if import asu_pkg::*; ();

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   logic                       final_sample;

   modport source (output valid, output sample, output final_sample, input ready);
   modport sink   (input valid, input sample, input final_sample, output ready);

endinterface

// ===== src/asu_rsp_if.sv =====
`timescale 1ns / 1ps
// result channel: one sorted element with the set statistics per transaction
interface asu_rsp_if import asu_pkg::*; ();

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sorted_value;
   logic                       end_of_run;
   logic signed [SAMPLE_W-1:0] largest;
   logic signed [SAMPLE_W-1:0] smallest;
   logic signed [MEAN_W-1:0]   mean_q8;
   logic signed [MEDIAN_W-1:0] median_doubled;
   logic        [COUNT_W-1:0]  sample_count;
   logic                       overflowed;

   modport source (output valid, output sorted_value, output end_of_run, output largest,
                   output smallest, output mean_q8, output median_doubled,
                   output sample_count, output overflowed, input ready);
   modport sink   (input valid, input sorted_value, input end_of_run, input largest,
                   input smallest, input mean_q8, input median_doubled,
                   input sample_count, input overflowed, output ready);

endinterface

// ===== src/array_sort_statistics_unit.sv =====
`timescale 1ns / 1ps
// top level: insertion sort chain with min, max, mean and median of each set
//
// req_chan carries one signed sample per transaction; final_sample closes a set.
// Samples are inserted into a chain of DEPTH cells, one per cycle, so while a
// set is loading req_chan.ready stays high. A sample that arrives with the chain
// full is dropped and flags the set as overflowed.
// After the final sample the block stops taking samples for a statistics pass:
// the chain rotates once to pick up minimum, maximum and the median pair,
// while a one-bit-per-cycle divider forms the mean. Then rsp_chan gives the
// n samples in ascending order, one per cycle while rsp_chan.ready is high,
// each with the set statistics; end_of_run marks the last. A stalled rsp_chan
// simply holds the current result. Latency from final sample to first result
// is the statistics pass. The next set is taken once the last result is taken.
// Reset (synchronous) empties the chain and clears count, sum and flag.
module array_sort_statistics_unit import asu_pkg::*; #(
   parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   asu_req_if.sink   req_chan,
   asu_rsp_if.source rsp_chan
);

   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam int unsigned SW = SAMPLE_W + $clog2(DEPTH);
   localparam int unsigned MW = SW + FRAC_W;

   localparam logic [1:0] ST_LOAD = 2'd0;
   localparam logic [1:0] ST_CALC = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]                 state_ff, state_in;
   logic [CW-1:0]              count_ff, count_in;
   logic signed [SW-1:0]       sum_ff, sum_in;
   logic                       drop_ff, drop_in;
   logic [CW-1:0]              step_ff, step_in;
   logic                       div_start_ff, div_start_in;
   logic signed [SAMPLE_W-1:0] smallest_ff, smallest_in;
   logic signed [SAMPLE_W-1:0] largest_ff, largest_in;
   logic signed [SAMPLE_W-1:0] mid_lo_ff, mid_lo_in;
   logic signed [SAMPLE_W-1:0] mid_hi_ff, mid_hi_in;
   logic signed [MEAN_W-1:0]   mean_ff, mean_in;
   logic signed [MEDIAN_W-1:0] median_ff, median_in;

   logic                       req_take;
   logic                       rsp_take;
   logic                       room;
   logic                       last_out;
   logic                       calc_done;
   cell_ctrl_type              ctrl;

   logic signed [SAMPLE_W-1:0] value_w [DEPTH];
   logic [DEPTH-1:0]           valid_w;
   logic [DEPTH-1:0]           gt_w;
   logic signed [SAMPLE_W-1:0] head;

   logic                       sum_neg;
   logic [SW-1:0]              sum_mag;
   logic                       div_busy;
   logic [MW-1:0]              quotient;
   logic [MEAN_W-1:0]          quo_low;
   logic [CW-1:0]              lo_idx;
   logic [CW-1:0]              hi_idx;

   assign head     = value_w[0];
   assign room     = count_ff < CW'(DEPTH);
   assign req_take = req_chan.valid && req_chan.ready;
   assign rsp_take = rsp_chan.valid && rsp_chan.ready;
   assign last_out = (step_ff == count_ff - 1'b1);
   assign lo_idx   = (count_ff - 1'b1) >> 1;
   assign hi_idx   = count_ff >> 1;
   assign calc_done = (step_ff == count_ff) && !div_start_ff && !div_busy;

   assign ctrl.insert = req_take && room;
   assign ctrl.rotate = (state_ff == ST_CALC) && (step_ff != count_ff);
   assign ctrl.drain  = rsp_take;
   assign ctrl.clear  = rsp_take && last_out;

   // insertion chain
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                       left_valid;
      logic                       left_gt;
      logic signed [SAMPLE_W-1:0] left_value;
      logic                       right_valid;
      logic signed [SAMPLE_W-1:0] right_value;
      if (i == 0) begin : g_first
         assign left_valid = 1'b1;
         assign left_gt    = 1'b0;
         assign left_value = '0;
      end else begin : g_inner
         assign left_valid = valid_w[i-1];
         assign left_gt    = gt_w[i-1];
         assign left_value = value_w[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_valid = 1'b0;
         assign right_value = '0;
      end else begin : g_body
         assign right_valid = valid_w[i+1];
         assign right_value = value_w[i+1];
      end
      asu_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .new_sample  (req_chan.sample),
         .left_valid  (left_valid),
         .left_gt     (left_gt),
         .left_value  (left_value),
         .right_valid (right_valid),
         .right_value (right_value),
         .wrap_value  (head),
         .value       (value_w[i]),
         .valid       (valid_w[i]),
         .gt          (gt_w[i])
      );
   end

   // mean: |sum| * 256 / n, sign restored afterwards
   assign sum_neg = sum_ff[SW-1];
   assign sum_mag = sum_neg ? SW'(-sum_ff) : SW'(sum_ff);

   asu_divider #(
      .DIVIDEND_W (MW),
      .DIVISOR_W  (CW)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend ({sum_mag, FRAC_W'(0)}),
      .divisor  (count_ff),
      .busy     (div_busy),
      .quotient (quotient)
   );

   assign quo_low = quotient[MEAN_W-1:0];

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      drop_in      = drop_ff;
      step_in      = step_ff;
      div_start_in = 1'b0;
      smallest_in  = smallest_ff;
      largest_in   = largest_ff;
      mid_lo_in    = mid_lo_ff;
      mid_hi_in    = mid_hi_ff;
      mean_in      = mean_ff;
      median_in    = median_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_take) begin
               if (room) begin
                  count_in = count_ff + 1'b1;
                  sum_in   = sum_ff + SW'(req_chan.sample);
               end else begin
                  drop_in = 1'b1;
               end
               if (req_chan.final_sample) begin
                  state_in     = ST_CALC;
                  step_in      = '0;
                  div_start_in = 1'b1;
               end
            end
         end
         ST_CALC: begin
            if (ctrl.rotate) begin
               // head walks through the set in ascending order
               if (step_ff == '0) smallest_in = head;
               if (step_ff == count_ff - 1'b1) largest_in = head;
               if (step_ff == lo_idx) mid_lo_in = head;
               if (step_ff == hi_idx) mid_hi_in = head;
               step_in = step_ff + 1'b1;
            end else if (calc_done) begin
               state_in  = ST_EMIT;
               step_in   = '0;
               mean_in   = sum_neg ? MEAN_W'(-quo_low) : MEAN_W'(quo_low);
               median_in = MEDIAN_W'(mid_lo_ff) + MEDIAN_W'(mid_hi_ff);
            end
         end
         ST_EMIT: begin
            if (rsp_take) begin
               step_in = step_ff + 1'b1;
               if (last_out) begin
                  state_in = ST_LOAD;
                  count_in = '0;
                  sum_in   = '0;
                  drop_in  = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         sum_ff       <= '0;
         drop_ff      <= 1'b0;
         step_ff      <= '0;
         div_start_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         drop_ff      <= drop_in;
         step_ff      <= step_in;
         div_start_ff <= div_start_in;
      end
   end

   always_ff @(posedge clock) begin
      smallest_ff <= smallest_in;
      largest_ff  <= largest_in;
      mid_lo_ff   <= mid_lo_in;
      mid_hi_ff   <= mid_hi_in;
      mean_ff     <= mean_in;
      median_ff   <= median_in;
   end

   assign req_chan.ready          = (state_ff == ST_LOAD);
   assign rsp_chan.valid          = (state_ff == ST_EMIT);
   assign rsp_chan.sorted_value   = head;
   assign rsp_chan.end_of_run     = last_out;
   assign rsp_chan.largest        = largest_ff;
   assign rsp_chan.smallest       = smallest_ff;
   assign rsp_chan.mean_q8        = mean_ff;
   assign rsp_chan.median_doubled = median_ff;
   assign rsp_chan.sample_count   = COUNT_W'(count_ff);
   assign rsp_chan.overflowed     = drop_ff;

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !req_chan.ready)
      else $error("sample taken while results pending");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("stored count beyond depth");

   a_chain_matches_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_EMIT) |-> ($countones(valid_w) == count_ff))
      else $error("occupied cells disagree with stored count");

   a_final_starts_calc: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_chan.final_sample) |=> (state_ff == ST_CALC && div_start_ff))
      else $error("final transaction did not start the statistics pass");

   a_run_end_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && rsp_chan.end_of_run) |=> (count_ff == '0 && valid_w == '0))
      else $error("set not cleared after last result");

endmodule

// ===== src/asu_cell.sv =====
`timescale 1ns / 1ps
// one cell of the insertion chain: holds one ordered sample and its valid bit
module asu_cell import asu_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  cell_ctrl_type              ctrl,
   input  logic signed [SAMPLE_W-1:0] new_sample,
   input  logic                       left_valid,
   input  logic                       left_gt,
   input  logic signed [SAMPLE_W-1:0] left_value,
   input  logic                       right_valid,
   input  logic signed [SAMPLE_W-1:0] right_value,
   input  logic signed [SAMPLE_W-1:0] wrap_value,
   output logic signed [SAMPLE_W-1:0] value,
   output logic                       valid,
   output logic                       gt
);

   logic signed [SAMPLE_W-1:0] value_ff, value_in;
   logic                       valid_ff, valid_in;
   logic                       take;

   assign gt   = valid_ff && (value_ff > new_sample);
   assign take = gt || (!valid_ff && left_valid);

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (ctrl.clear) begin
         valid_in = 1'b0;
      end else if (ctrl.drain) begin
         value_in = right_value;
         valid_in = right_valid;
      end else if (ctrl.rotate) begin
         if (valid_ff) begin
            value_in = right_valid ? right_value : wrap_value;
         end
      end else if (ctrl.insert) begin
         if (take) begin
            value_in = left_gt ? left_value : new_sample;
            valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;
   assign valid = valid_ff;

endmodule

// ===== src/asu_divider.sv =====
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle
module asu_divider import asu_pkg::*; #(
   parameter int unsigned DIVIDEND_W = 30,
   parameter int unsigned DIVISOR_W  = 7
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  busy,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int unsigned STEP_W = $clog2(DIVIDEND_W + 1);

   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  divisor_ff, divisor_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic                  busy_ff, busy_in;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;

   assign trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign diff  = trial - {1'b0, divisor_ff};
   assign fits  = trial >= {1'b0, divisor_ff};

   always_comb begin
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      step_in    = step_ff;
      busy_in    = busy_ff;
      if (start) begin
         quo_in     = dividend;
         rem_in     = '0;
         divisor_in = divisor;
         step_in    = STEP_W'(DIVIDEND_W);
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[DIVIDEND_W-2:0], fits};
         rem_in  = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         step_in = step_ff - 1'b1;
         busy_in = (step_ff != STEP_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

// ===== tb/tb_array_sort_statistics_unit.sv =====
`timescale 1ns / 1ps
// testbench for the sort statistics unit: directed and random sets checked against a sorted-set predictor
module tb_array_sort_statistics_unit import asu_pkg::*;;

   localparam int SET_DEPTH    = DEPTH_DEFAULT;
   localparam int RANDOM_ITEMS = 450;
   localparam int DRAIN_CYCLES = 100;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sorted_value;
      logic                       end_of_run;
      logic signed [SAMPLE_W-1:0] largest;
      logic signed [SAMPLE_W-1:0] smallest;
      logic signed [MEAN_W-1:0]   mean_q8;
      logic signed [MEDIAN_W-1:0] median_doubled;
      logic        [COUNT_W-1:0]  sample_count;
      logic                       overflowed;
   } set_element_type;

   typedef enum logic [1:0] {
      RX_STEADY,
      RX_COIN,
      RX_THIRDS,
      RX_LONG_STALL
   } rx_pattern_type;

   class sort_stats_scoreboard;
      int              ranked_samples[$];
      int              set_sum;
      bit              set_dropped;
      set_element_type due_elements[$];
      int              failures;

      function void absorb_sample(input logic signed [SAMPLE_W-1:0] value, input logic fin);
         int              pos;
         int              n;
         int              mean;
         int              med2;
         set_element_type e;
         if (ranked_samples.size() < SET_DEPTH) begin
            pos = ranked_samples.size();
            while (pos > 0 && ranked_samples[pos-1] > int'(value))
               pos--;
            ranked_samples.insert(pos, int'(value));
            set_sum += int'(value);
         end else begin
            set_dropped = 1'b1;
         end
         if (!fin)
            return;
         n = ranked_samples.size();
         if (n > 0) begin
            mean = (set_sum * 256) / n;
            if (n % 2 == 0)
               med2 = ranked_samples[n/2-1] + ranked_samples[n/2];
            else
               med2 = 2 * ranked_samples[(n-1)/2];
            for (int i = 0; i < n; i++) begin
               e.sorted_value   = SAMPLE_W'(ranked_samples[i]);
               e.end_of_run     = (i == n - 1);
               e.largest        = SAMPLE_W'(ranked_samples[n-1]);
               e.smallest       = SAMPLE_W'(ranked_samples[0]);
               e.mean_q8        = MEAN_W'(mean);
               e.median_doubled = MEDIAN_W'(med2);
               e.sample_count   = COUNT_W'(n);
               e.overflowed     = set_dropped;
               due_elements.push_back(e);
            end
         end
         ranked_samples.delete();
         set_sum     = 0;
         set_dropped = 1'b0;
      endfunction

      function void check_element(input set_element_type got);
         set_element_type want;
         if (due_elements.size() == 0) begin
            $error("unexpected result transaction: sorted_value %0d", got.sorted_value);
            failures++;
            return;
         end
         want = due_elements.pop_front();
         if (got.sorted_value !== want.sorted_value) begin
            $error("sorted_value: expected %0d, got %0d", want.sorted_value, got.sorted_value);
            failures++;
         end
         if (got.end_of_run !== want.end_of_run) begin
            $error("end_of_run: expected %0d, got %0d", want.end_of_run, got.end_of_run);
            failures++;
         end
         if (got.largest !== want.largest) begin
            $error("largest: expected %0d, got %0d", want.largest, got.largest);
            failures++;
         end
         if (got.smallest !== want.smallest) begin
            $error("smallest: expected %0d, got %0d", want.smallest, got.smallest);
            failures++;
         end
         if (got.mean_q8 !== want.mean_q8) begin
            $error("mean_q8: expected %0d, got %0d", want.mean_q8, got.mean_q8);
            failures++;
         end
         if (got.median_doubled !== want.median_doubled) begin
            $error("median_doubled: expected %0d, got %0d",
                   want.median_doubled, got.median_doubled);
            failures++;
         end
         if (got.sample_count !== want.sample_count) begin
            $error("sample_count: expected %0d, got %0d", want.sample_count, got.sample_count);
            failures++;
         end
         if (got.overflowed !== want.overflowed) begin
            $error("overflowed: expected %0d, got %0d", want.overflowed, got.overflowed);
            failures++;
         end
      endfunction

      function int pending();
         return due_elements.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   int   burst_left;

   sort_stats_scoreboard book = new();

   asu_req_if req_chan();
   asu_rsp_if rsp_chan();

   array_sort_statistics_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // called at a falling edge, returns at the falling edge after the transaction
   task automatic send_sample(input logic [SAMPLE_W-1:0] value, input logic fin);
      int pause;
      if (burst_left == 0) begin
         pause = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
         for (int k = 0; k < pause; k++) begin
            req_chan.valid        <= 1'b0;
            req_chan.sample       <= SAMPLE_W'($urandom);
            req_chan.final_sample <= 1'($urandom);
            @(negedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                  : $urandom_range(1, 12);
      end
      req_chan.valid        <= 1'b1;
      req_chan.sample       <= value;
      req_chan.final_sample <= fin;
      do
         @(posedge clock);
      while (!req_chan.ready);
      book.absorb_sample(value, fin);
      burst_left--;
      @(negedge clock);
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      logic [SAMPLE_W-1:0] v;
      case ($urandom_range(0, 9))
         5, 6:    v = SAMPLE_W'($urandom_range(0, 8) - 4);
         7:       v = SAMPLE_W'(16'h8000 + $urandom_range(0, 2));
         8:       v = SAMPLE_W'(16'h7FFF - $urandom_range(0, 2));
         9:       v = SAMPLE_W'($urandom_range(0, 200) - 100);
         default: v = SAMPLE_W'($urandom);
      endcase
      return v;
   endfunction

   initial begin
      int set_idx;
      int set_len;
      int sent_random;
      req_chan.valid        = 1'b0;
      req_chan.sample       = '0;
      req_chan.final_sample = 1'b0;
      reset                 = 1'b1;
      burst_left            = 0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // single-element sets at both extremes, then the pair 0 and -1
      send_sample(16'h7FFF, 1'b1);
      send_sample(16'h8000, 1'b1);
      send_sample(16'h0000, 1'b0); send_sample(16'hFFFF, 1'b1);
      // equal samples
      send_sample(16'd7, 1'b0); send_sample(16'd7, 1'b0); send_sample(16'd7, 1'b1);
      // even set spanning the full range
      send_sample(16'h7FFF, 1'b0); send_sample(16'h8000, 1'b1);
      send_sample(-16'sd5, 1'b0); send_sample(16'd3, 1'b0); send_sample(-16'sd5, 1'b0);
      send_sample(16'd3, 1'b0); send_sample(16'd0, 1'b1);
      send_sample(16'd100, 1'b0); send_sample(-16'sd100, 1'b0); send_sample(16'd50, 1'b0);
      send_sample(-16'sd50, 1'b1);
      send_sample(16'h8000, 1'b0); send_sample(16'h8000, 1'b0); send_sample(16'h8000, 1'b1);
      // negative mean truncated toward zero
      send_sample(-16'sd1, 1'b0); send_sample(16'd0, 1'b0); send_sample(16'd0, 1'b1);

      set_idx     = 0;
      sent_random = 0;
      while (sent_random < RANDOM_ITEMS) begin
         if (set_idx == 0)
            set_len = SET_DEPTH;
         else if (set_idx == 1)
            set_len = SET_DEPTH + 3;
         else if ($urandom_range(0, 9) == 0)
            set_len = $urandom_range(SET_DEPTH - 4, SET_DEPTH + 6);
         else
            set_len = $urandom_range(1, 12);
         for (int k = 1; k <= set_len; k++)
            send_sample(pick_sample(), k == set_len);
         sent_random += set_len;
         set_idx++;
      end
      req_chan.valid <= 1'b0;

      while (book.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (book.failures == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      rx_pattern_type pattern;
      int             hold;
      int             tick;
      hold           = 0;
      tick           = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         pattern = rx_pattern_type'($urandom_range(0, 3));
         repeat ($urandom_range(40, 300)) begin
            @(negedge clock);
            tick++;
            case (pattern)
               RX_STEADY: rsp_chan.ready <= 1'b1;
               RX_COIN:   rsp_chan.ready <= 1'($urandom_range(0, 1));
               RX_THIRDS: rsp_chan.ready <= (tick % 3 == 0);
               default: begin
                  if (hold == 0) begin
                     if (rsp_chan.ready) begin
                        rsp_chan.ready <= 1'b0;
                        hold = $urandom_range(5, 20);
                     end else begin
                        rsp_chan.ready <= 1'b1;
                        hold = $urandom_range(1, 4);
                     end
                  end else begin
                     hold--;
                  end
               end
            endcase
         end
      end
   end

   always @(posedge clock) begin
      set_element_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.sorted_value   = rsp_chan.sorted_value;
         got.end_of_run     = rsp_chan.end_of_run;
         got.largest        = rsp_chan.largest;
         got.smallest       = rsp_chan.smallest;
         got.mean_q8        = rsp_chan.mean_q8;
         got.median_doubled = rsp_chan.median_doubled;
         got.sample_count   = rsp_chan.sample_count;
         got.overflowed     = rsp_chan.overflowed;
         book.check_element(got);
      end
   end

   initial begin
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== array_sort_statistics_unit.f =====
src/asu_pkg.sv
src/asu_req_if.sv
src/asu_rsp_if.sv
src/asu_cell.sv
src/asu_divider.sv
src/array_sort_statistics_unit.sv
tb/tb_array_sort_statistics_unit.sv
